[sv/priority_round_robin_scheduler_top_assert.svh]
// assertion macros for the scheduler
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
// property that must hold on every clock once out of reset
`define PRRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after its cause
`define PRRS_ASSERT_NEXT(lbl, clk, rst_n, cause, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cons)) \
        else $error(msg);
`endif

[sv/prrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// shared types and codes of the priority round-robin scheduler
// ----------------------------------------------------------------------------
package prrs_pkg;
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_DELAY = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_TICK, S_FIRST, S_GROUP, S_TRY, S_DONE
    } t_state;

    // per-cell controls driven by the sequencer
    typedef struct packed {
        logic       shift;   // move entry right by one slot
        logic       tick;    // count timeout down
        logic       load;    // write new entry at ins slot
        logic       set_to;  // write timeout at current slot
    } t_cell_ctl;
endpackage

[sv/prrs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_cell
// one slot: priority, thread id and timeout; takes its left neighbor's entry
// ----------------------------------------------------------------------------
module prrs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prrs_pkg::t_cell_ctl i_ctl,
    input  logic                i_active,     // slot index plus one below thread count
    input  logic                i_shift_en,   // this slot is right of insertion, at or below thread count
    input  logic                i_load_here,
    input  logic                i_to_here,
    input  logic [4:0]          i_new_prio,
    input  logic [4:0]          i_new_id,
    input  logic [31:0]         i_delay,
    input  logic [4:0]          i_left_prio,
    input  logic [4:0]          i_left_id,
    input  logic [31:0]         i_left_to,
    output logic [4:0]          o_prio,
    output logic [4:0]          o_id,
    output logic [31:0]         o_to,
    output logic                o_wake
);
    import prrs_pkg::*;

    logic [4:0]  r_prio, n_prio;
    logic [4:0]  r_id, n_id;
    logic [31:0] r_to, n_to;

    always_comb begin
        n_prio = r_prio;
        n_id   = r_id;
        n_to   = r_to;
        o_wake = 1'b0;
        if (i_ctl.shift && i_shift_en) begin
            n_prio = i_left_prio;
            n_id   = i_left_id;
            n_to   = i_left_to;
        end
        if (i_ctl.load && i_load_here) begin
            n_prio = i_new_prio;
            n_id   = i_new_id;
            n_to   = '0;
        end
        if (i_ctl.set_to && i_to_here) n_to = i_delay;
        if (i_ctl.tick && i_active && r_to != '0) begin
            n_to   = r_to - 32'd1;
            o_wake = (r_to == 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_to <= '0;
        end else begin
            r_to <= n_to;
        end
        r_prio <= n_prio;
        r_id   <= n_id;
    end

    assign o_prio = r_prio;
    assign o_id   = r_id;
    assign o_to   = r_to;
endmodule

[sv/priority_round_robin_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_top
// fixed-priority round-robin thread scheduler over a row of slot cells
// ----------------------------------------------------------------------------
// One item per start pulse while busy is low; one result per item, shown for
// a single cycle on o_valid, which the receiver must take as it comes. Tick
// items count the cell row down in parallel. Add items find the insertion
// slot one slot a cycle from the end before the row shifts. Start and delay
// items run the scheduling sequencer, which walks the slots one per cycle:
// up to the first ready slot, back to its group's first slot, then one try
// per cycle.
module priority_round_robin_scheduler_top #(
    parameter int MAX_SLOTS      = 32,
    parameter int NUM_PRIORITIES = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_priority_req,
    input  logic [31:0] i_delay_ticks,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_switched,
    output logic [4:0]  o_next_thread,
    output logic [4:0]  o_prev_thread,
    output logic [4:0]  o_new_thread
);
    import prrs_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int GW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    t_state r_state, n_state;
    logic [MAX_SLOTS-1:0] r_ready, n_ready;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_cur, n_cur;
    logic r_started, n_started;
    logic [CW-1:0] r_gcnt [NUM_PRIORITIES];
    logic [SW-1:0] r_gptr [NUM_PRIORITIES];
    logic [CW-1:0] n_gcnt [NUM_PRIORITIES];
    logic [SW-1:0] n_gptr [NUM_PRIORITIES];

    logic [1:0]  r_mode;
    logic [4:0]  r_prio;
    logic [31:0] r_delay;
    logic [SW-1:0] r_ins, n_ins;
    logic [CW-1:0] r_scan, n_scan;  // scan / base slot
    logic [SW-1:0] r_first, n_first;
    logic [CW-1:0] r_try, n_try;
    logic r_had_prev, n_had_prev;
    logic [4:0] r_prev_id, n_prev_id;

    logic r_valid, n_valid;
    logic [1:0] r_status, n_status;
    logic r_sw, n_sw;
    logic [4:0] r_next, n_next, r_prevo, n_prevo, r_newt, n_newt;

    t_cell_ctl ctl;
    logic [4:0]  c_prio [MAX_SLOTS];
    logic [4:0]  c_id   [MAX_SLOTS];
    logic [31:0] c_to   [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] c_wake;

    logic [4:0] sat_prio;
    assign sat_prio = ({1'b0, r_prio} >= 6'(NUM_PRIORITIES)) ? 5'(NUM_PRIORITIES - 1)
                                                             : r_prio;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
            logic [4:0]  lp;
            logic [4:0]  li;
            logic [31:0] lt;
            if (gi == 0) begin : g_edge
                assign lp = '0;
                assign li = '0;
                assign lt = '0;
            end else begin : g_mid
                assign lp = c_prio[gi-1];
                assign li = c_id[gi-1];
                assign lt = c_to[gi-1];
            end
            prrs_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_active   (CW'(gi + 1) < r_count),
                .i_shift_en (SW'(gi) > r_ins && CW'(gi) <= r_count),
                .i_load_here(SW'(gi) == r_ins),
                .i_to_here  (SW'(gi) == r_cur),
                .i_new_prio (sat_prio),
                .i_new_id   (5'(r_count)),
                .i_delay    (r_delay),
                .i_left_prio(lp),
                .i_left_id  (li),
                .i_left_to  (lt),
                .o_prio     (c_prio[gi]),
                .o_id       (c_id[gi]),
                .o_to       (c_to[gi]),
                .o_wake     (c_wake[gi])
            );
        end
    endgenerate

    // scan helpers (one slot per cycle)
    logic [SW-1:0] scan_s;
    logic [GW-1:0] grp;
    logic [CW-1:0] gc;
    logic [SW-1:0] gp;
    logic [SW:0]   idx_w;
    logic [SW-1:0] idx;
    logic          idx_rdy;
    logic [SW:0]   gp_inc;
    assign scan_s  = r_scan[SW-1:0];
    // stored priorities are already saturated below NUM_PRIORITIES
    assign grp     = GW'(c_prio[scan_s]);
    assign gc      = r_gcnt[grp];
    assign gp      = r_gptr[grp];
    assign idx_w   = {1'b0, scan_s} + {1'b0, gp};
    assign idx     = idx_w[SW-1:0];
    assign idx_rdy = (CW'(idx_w) < r_count) && !idx_w[SW] && r_ready[idx];
    assign gp_inc  = {1'b0, gp} + 1'b1;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_ready = r_ready; n_count = r_count; n_cur = r_cur;
        n_started = r_started; n_ins = r_ins; n_scan = r_scan; n_first = r_first;
        n_try = r_try; n_had_prev = r_had_prev; n_prev_id = r_prev_id;
        n_gcnt = r_gcnt; n_gptr = r_gptr;
        n_valid = 1'b0; n_status = r_status; n_sw = r_sw; n_next = r_next;
        n_prevo = r_prevo; n_newt = r_newt;
        ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_OK; n_sw = 1'b0; n_next = '0; n_prevo = '0; n_newt = '0;
                    n_scan = '0;
                    n_ins = r_count[SW-1:0];
                    n_state = S_DONE;
                    unique case (i_mode)
                        MODE_ADD: begin
                            if (r_started) n_status = ST_REJECTED;
                            else if (r_count == CW'(MAX_SLOTS)) n_status = ST_FULL;
                            else n_state = S_SHIFT;
                        end
                        MODE_START: begin
                            if (r_count != '0) begin
                                n_had_prev = r_started;
                                n_started = 1'b1;
                                for (int k = 0; k < MAX_SLOTS; k++)
                                    if (CW'(k) < r_count) n_ready[k] = 1'b1;
                                n_prev_id = c_id[r_cur];
                                n_state = S_FIRST;
                            end
                        end
                        MODE_DELAY: begin
                            if (r_started) begin
                                n_had_prev = 1'b1;
                                n_ready[r_cur] = 1'b0;
                                n_prev_id = c_id[r_cur];
                                n_state = S_FIRST;
                            end
                        end
                        default: n_state = S_TICK;
                    endcase
                end
            end
            S_SHIFT: begin
                // find insertion slot: walk down from the end one slot a cycle
                if (r_ins != '0 && c_prio[r_ins - 1'b1] > sat_prio) begin
                    n_ins = r_ins - 1'b1;
                end else begin
                    ctl.shift = 1'b1;
                    ctl.load  = 1'b1;
                    n_gcnt[GW'(sat_prio)] = r_gcnt[GW'(sat_prio)] + 1'b1;
                    n_newt = 5'(r_count);
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_TICK: begin
                ctl.tick = 1'b1;
                n_ready = r_ready | c_wake;
                n_state = S_DONE;
            end
            S_FIRST: begin
                if (r_mode == MODE_DELAY && r_scan == '0) ctl.set_to = 1'b1;
                if (r_scan >= r_count) begin
                    n_state = S_DONE;
                end else if (r_ready[scan_s]) begin
                    n_first = scan_s;
                    if (r_scan == r_count - 1'b1) begin
                        n_cur = scan_s; n_sw = 1'b1; n_next = c_id[scan_s];
                        n_prevo = r_had_prev ? r_prev_id : 5'd0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GROUP;
                    end
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_GROUP: begin
                // walk back to the group's first slot
                if (r_scan != '0 && c_prio[scan_s - 1'b1] == c_prio[r_first]) begin
                    n_scan = r_scan - 1'b1;
                end else begin
                    n_try = '0;
                    n_state = S_TRY;
                end
            end
            default: begin
                if (r_state == S_TRY) begin
                    if (r_scan >= r_count || gc == '0) begin
                        n_cur = r_first; n_sw = 1'b1; n_next = c_id[r_first];
                        n_prevo = r_had_prev ? r_prev_id : 5'd0;
                        n_state = S_DONE;
                    end else begin
                        n_gptr[grp] = (CW'(gp_inc) >= gc) ? '0 : gp_inc[SW-1:0];
                        if (idx_rdy) begin
                            n_cur = idx; n_sw = 1'b1; n_next = c_id[idx];
                            n_prevo = r_had_prev ? r_prev_id : 5'd0;
                            n_state = S_DONE;
                        end else if (r_try + 1'b1 >= gc) begin
                            n_try = '0;
                            n_scan = r_scan + gc;
                        end else begin
                            n_try = r_try + 1'b1;
                        end
                    end
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ready <= '0; r_count <= '0; r_cur <= '0;
            r_started <= 1'b0; r_valid <= 1'b0;
            for (int k = 0; k < NUM_PRIORITIES; k++) begin
                r_gcnt[k] <= '0; r_gptr[k] <= '0;
            end
        end else begin
            r_state <= n_state; r_ready <= n_ready; r_count <= n_count; r_cur <= n_cur;
            r_started <= n_started; r_valid <= n_valid;
            r_gcnt <= n_gcnt; r_gptr <= n_gptr;
        end
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode; r_prio <= i_priority_req; r_delay <= i_delay_ticks;
        end
        r_ins <= n_ins; r_scan <= n_scan; r_first <= n_first; r_try <= n_try;
        r_had_prev <= n_had_prev; r_prev_id <= n_prev_id;
        r_status <= n_status; r_sw <= n_sw; r_next <= n_next; r_prevo <= n_prevo;
        r_newt <= n_newt;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_switched    = r_sw;
    assign o_next_thread = r_next;
    assign o_prev_thread = r_prevo;
    assign o_new_thread  = r_newt;

    `include "priority_round_robin_scheduler_top_assert.svh"
    `PRRS_ASSERT(a_valid_idle, i_clk, i_rst_n, o_valid |-> r_state == S_IDLE, "result while busy")
    `PRRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "not busy after accept")
    `PRRS_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_SLOTS), "thread count overflow")
    `PRRS_ASSERT(a_sw_started, i_clk, i_rst_n, (o_valid && o_switched) |-> r_started, "switch before start")
endmodule
